/* rtl/lfu_pkg.sv */
// Shared types and constants for the LFU cache table.
`default_nettype none

package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

endpackage

`default_nettype wire

/* rtl/lfu_req_if.sv */
// Request channel: get or put of a key/value pair.
`default_nettype none

interface lfu_req_if import lfu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [KEY_W-1:0]  req_key;
    logic signed [DATA_W-1:0] req_value;

    modport source (output valid, req_type, req_key, req_value, input ready);
    modport sink   (input valid, req_type, req_key, req_value, output ready);
endinterface

`default_nettype wire

/* rtl/lfu_rsp_if.sv */
// Response channel: hit, read value and eviction report.
`default_nettype none

interface lfu_rsp_if import lfu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

/* rtl/lfu_cfg_if.sv */
// Configuration write channel for the capacity register.
`default_nettype none

interface lfu_cfg_if import lfu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

/* rtl/lfu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* rtl/lfu_cache_table.sv */
// LFU cache table: one request at a time, from accept through scan to a registered response.
// Each request takes a scan of the entry RAM (one read a cycle), a drain state and a
// read-modify-write decision state; the RAM's single read port sets the rate.
// The next request can be accepted once the response is registered and the FSM is back in
// idle; a response still waiting to be taken holds the decision state.
// Synchronous reset clears the valid bits, occupancy, stamp clock and response valid and
// sets capacity to 16; entry contents are not cleared and are read only when valid.
`default_nettype none

module lfu_cache_table import lfu_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    lfu_cfg_if.sink   i_cfg
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [DATA_W-1:0]     data;
        logic [COUNT_BITS-1:0] cnt;
        logic [STAMP_W-1:0]    stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_addr, n_addr;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [STAMP_W-1:0]     r_stamp_clk, n_stamp_clk;
    logic [CAP_W-1:0]       r_capacity;

    // latched request
    logic                   r_type;
    logic [KEY_W-1:0]       r_key;
    logic [DATA_W-1:0]      r_value;

    // scan results
    logic                   r_hit_found, n_hit_found;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic [DATA_W-1:0]      r_hit_data, n_hit_data;
    logic [COUNT_BITS-1:0]  r_hit_cnt, n_hit_cnt;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   r_vic_found, n_vic_found;
    logic [IDX_W-1:0]       r_vic_idx, n_vic_idx;
    logic [KEY_W-1:0]       r_vic_key, n_vic_key;
    logic [COUNT_BITS-1:0]  r_vic_cnt, n_vic_cnt;
    logic [STAMP_W-1:0]     r_vic_age, n_vic_age;

    // response register
    logic                   r_out_vld, n_out_vld;
    logic                   r_hit, n_hit;
    logic [DATA_W-1:0]      r_rd_val, n_rd_val;
    logic                   r_evicted, n_evicted;
    logic [KEY_W-1:0]       r_ev_key, n_ev_key;

    // RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    t_entry                 ram_wdata;
    t_entry                 ram_rdata;
    logic [ENTRY_W-1:0]     ram_rdata_raw;

    logic                   req_acc;
    logic [STAMP_W-1:0]     rd_age;
    logic [CMP_W-1:0]       cap_ext, cap_eff;
    logic                   rd_valid;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata   = t_entry'(ram_rdata_raw);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.read_value  = r_rd_val;
    assign o_rsp.evicted     = r_evicted;
    assign o_rsp.evicted_key = r_ev_key;

    assign rd_valid = r_valid[r_cmp_idx];
    assign rd_age   = r_stamp_clk - ram_rdata.stamp;
    assign cap_ext  = CMP_W'(r_capacity);
    assign cap_eff  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp_clk <= '0;
            r_capacity  <= CAP_RESET;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_stamp_clk <= n_stamp_clk;
            r_out_vld   <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_data   <= n_hit_data;
        r_hit_cnt    <= n_hit_cnt;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vic_found  <= n_vic_found;
        r_vic_idx    <= n_vic_idx;
        r_vic_key    <= n_vic_key;
        r_vic_cnt    <= n_vic_cnt;
        r_vic_age    <= n_vic_age;
        r_hit        <= n_hit;
        r_rd_val     <= n_rd_val;
        r_evicted    <= n_evicted;
        r_ev_key     <= n_ev_key;
        if (req_acc) begin
            r_type  <= i_req.req_type;
            r_key   <= i_req.req_key;
            r_value <= i_req.req_value;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_addr;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_stamp_clk  = r_stamp_clk;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_data   = r_hit_data;
        n_hit_cnt    = r_hit_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic_key    = r_vic_key;
        n_vic_cnt    = r_vic_cnt;
        n_vic_age    = r_vic_age;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_hit        = r_hit;
        n_rd_val     = r_rd_val;
        n_evicted    = r_evicted;
        n_ev_key     = r_ev_key;
        ram_we       = 1'b0;
        ram_waddr    = r_hit_idx;
        ram_wdata    = '0;

        // compare stage: one entry per cycle, read data arriving the cycle after its address
        if (r_cmp_vld) begin
            if (rd_valid && ram_rdata.key == r_key && !r_hit_found) begin
                n_hit_found = 1'b1;
                n_hit_idx   = r_cmp_idx;
                n_hit_data  = ram_rdata.data;
                n_hit_cnt   = ram_rdata.cnt;
            end
            if (!rd_valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_cmp_idx;
            end
            if (rd_valid && (!r_vic_found || ram_rdata.cnt < r_vic_cnt ||
                             (ram_rdata.cnt == r_vic_cnt && rd_age > r_vic_age))) begin
                n_vic_found = 1'b1;
                n_vic_idx   = r_cmp_idx;
                n_vic_key   = ram_rdata.key;
                n_vic_cnt   = ram_rdata.cnt;
                n_vic_age   = rd_age;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_state      = ST_SCAN;
                    n_addr       = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_vic_found  = 1'b0;
                end
            end
            ST_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr;
                if (r_addr == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // the write lands before the next scan can read, so no forwarding needed
                if (!r_out_vld || o_rsp.ready) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    n_hit     = 1'b0;
                    n_rd_val  = '0;
                    n_evicted = 1'b0;
                    n_ev_key  = '0;
                    if (r_hit_found) begin
                        n_hit           = 1'b1;
                        ram_we          = 1'b1;
                        ram_waddr       = r_hit_idx;
                        ram_wdata.key   = r_key;
                        ram_wdata.data  = (r_type == REQ_PUT) ? r_value : r_hit_data;
                        ram_wdata.cnt   = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + 1'b1;
                        ram_wdata.stamp = r_stamp_clk;
                        n_stamp_clk     = r_stamp_clk + 1'b1;
                        if (r_type == REQ_GET) begin
                            n_rd_val = r_hit_data;
                        end
                    end else if (r_type == REQ_PUT && cap_eff != '0) begin
                        ram_wdata.key   = r_key;
                        ram_wdata.data  = r_value;
                        ram_wdata.cnt   = COUNT_BITS'(1);
                        ram_wdata.stamp = r_stamp_clk;
                        if (CMP_W'(r_occ) < cap_eff && r_free_found) begin
                            ram_we             = 1'b1;
                            ram_waddr          = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                            n_occ              = r_occ + 1'b1;
                            n_stamp_clk        = r_stamp_clk + 1'b1;
                        end else if (r_vic_found) begin
                            // evict and refill the same slot: occupancy unchanged
                            ram_we      = 1'b1;
                            ram_waddr   = r_vic_idx;
                            n_evicted   = 1'b1;
                            n_ev_key    = r_vic_key;
                            n_stamp_clk = r_stamp_clk + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy differs from number of valid entries");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.evicted |-> !o_rsp.hit)
        else $error("eviction reported on a hit");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_state == ST_SCAN && r_addr == '0)
        else $error("accepted request did not start a scan at entry zero");

    a_stamp_only_on_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_stamp_clk != $past(r_stamp_clk) |->
            $past(r_state) == ST_DECIDE && r_out_vld)
        else $error("stamp clock moved outside a decision");
endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the LFU cache table: directed table, then random phases.
`default_nettype none

module testbench import lfu_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES     = 16;
    localparam int COUNT_BITS      = 16;
    localparam int POOL_SIZE       = 24;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 2 * (MAX_ENTRIES + 3);
    localparam int EXP_DEPTH       = 8;
    localparam int DIR_DEPTH       = 32;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } t_lookup_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              fixed;
        t_lookup_result    result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    lfu_req_if req_bus ();
    lfu_rsp_if rsp_bus ();
    lfu_cfg_if cfg_bus ();

    lfu_cache_table #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // shadow of the cache contents
    logic                  ent_live  [MAX_ENTRIES];
    logic [KEY_W-1:0]      ent_key   [MAX_ENTRIES];
    logic [DATA_W-1:0]     ent_val   [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] ent_uses  [MAX_ENTRIES];
    logic [STAMP_W-1:0]    ent_stamp [MAX_ENTRIES];
    logic [STAMP_W-1:0]    stamp_now;
    int                    fill_level;
    logic [CAP_W-1:0]      cap_shadow;

    // expected results in request order, ring of EXP_DEPTH
    t_lookup_result   exp_buf [EXP_DEPTH];
    int               exp_wr;
    int               exp_rd;
    t_stim_row        dir_rows [DIR_DEPTH];
    int               dir_count;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [CAP_W-1:0] phase_caps [8] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd2, 5'd16, 5'd7};

    int req_count;
    int rsp_count;
    int fail_count;
    int burst_left;
    int stall_cycles;
    bit steady_send;
    bit hold_rsp;

    // tags riding along with the request payload
    logic           row_fixed;
    t_lookup_result row_result;

    function automatic void touch_entry(int s);
        if (ent_uses[s] != {COUNT_BITS{1'b1}})
            ent_uses[s] = ent_uses[s] + 1'b1;
        ent_stamp[s] = stamp_now;
        stamp_now    = stamp_now + 1'b1;
    endfunction

    function automatic t_lookup_result predict_lookup(logic op, logic [KEY_W-1:0] k,
                                                      logic [DATA_W-1:0] v);
        t_lookup_result        r;
        int                    found;
        int                    slot;
        int                    eff_cap;
        logic [COUNT_BITS-1:0] best_uses;
        logic [STAMP_W-1:0]    best_age;
        logic [STAMP_W-1:0]    age;

        r     = '0;
        found = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (found < 0 && ent_live[i] && ent_key[i] == k)
                found = i;
        eff_cap = (cap_shadow > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_shadow);

        if (found >= 0) begin
            r.hit = 1'b1;
            if (op == REQ_GET)
                r.read_value = ent_val[found];
            else
                ent_val[found] = v;
            touch_entry(found);
            return r;
        end
        if (op == REQ_GET || eff_cap == 0)
            return r;

        slot = -1;
        if (fill_level < eff_cap)
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot < 0 && !ent_live[i])
                    slot = i;
        if (slot < 0) begin
            // lowest count wins, oldest touch breaks the tie
            best_uses = '0;
            best_age  = '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (ent_live[i]) begin
                    age = stamp_now - ent_stamp[i];
                    if (slot < 0 || ent_uses[i] < best_uses ||
                        (ent_uses[i] == best_uses && age > best_age)) begin
                        slot      = i;
                        best_uses = ent_uses[i];
                        best_age  = age;
                    end
                end
            end
            if (slot < 0)
                return r;
            r.evicted     = 1'b1;
            r.evicted_key = ent_key[slot];
            ent_live[slot] = 1'b0;
            if (fill_level > 0)
                fill_level--;
        end
        ent_live[slot] = 1'b1;
        ent_key[slot]  = k;
        ent_val[slot]  = v;
        ent_uses[slot] = '0;
        touch_entry(slot);
        fill_level++;
        return r;
    endfunction

    function automatic t_lookup_result mk_result(logic h, logic [DATA_W-1:0] rv, logic ev,
                                                 logic [KEY_W-1:0] ek);
        t_lookup_result r;
        r.hit         = h;
        r.read_value  = rv;
        r.evicted     = ev;
        r.evicted_key = ek;
        return r;
    endfunction

    function automatic void add_req(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v,
                                    logic fixed, t_lookup_result r);
        t_stim_row row;
        row.kind   = ROW_REQ;
        row.op     = op;
        row.key    = k;
        row.value  = v;
        row.fixed  = fixed;
        row.result = r;
        dir_rows[dir_count] = row;
        dir_count++;
    endfunction

    function automatic void add_cfg(logic [CAP_W-1:0] c);
        t_stim_row row;
        row     = '0;
        row.kind = ROW_CFG;
        row.key  = {{(KEY_W-CAP_W){1'b0}}, c};
        dir_rows[dir_count] = row;
        dir_count++;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic send_req(input logic op, input logic [KEY_W-1:0] k,
                            input logic [DATA_W-1:0] v, input logic fixed,
                            input t_lookup_result r);
        bit took;
        if (!steady_send && burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = int'($urandom_range(1, 12));
        end
        if (burst_left > 0)
            burst_left--;
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= op;
        req_bus.req_key   <= k;
        req_bus.req_value <= v;
        row_fixed         <= fixed;
        row_result        <= r;
        do begin
            @(negedge i_clk);
            took = req_bus.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (rsp_count != req_count)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        bit took;
        wait_idle();
        cfg_bus.valid    <= 1'b1;
        cfg_bus.capacity <= c;
        do begin
            @(negedge i_clk);
            took = cfg_bus.ready;
            @(posedge i_clk);
        end while (!took);
        cap_shadow = c;
        cfg_bus.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                want = predict_lookup(req_bus.req_type, req_bus.req_key, req_bus.req_value);
                if (row_fixed)
                    want = row_result;
                if (exp_wr - exp_rd >= EXP_DEPTH) begin
                    $error("more requests outstanding than the checker can hold");
                    fail_count++;
                end else begin
                    exp_buf[exp_wr % EXP_DEPTH] = want;
                    exp_wr++;
                end
                req_count++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_count++;
                if (exp_wr == exp_rd) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    want = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    check_field("hit", want.hit, rsp_bus.hit);
                    check_field("read_value", want.read_value, rsp_bus.read_value);
                    check_field("evicted", want.evicted, rsp_bus.evicted);
                    check_field("evicted_key", want.evicted_key, rsp_bus.evicted_key);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // response side stalls in runs; a long hold is counted here on request
    initial begin : rsp_pacing
        rsp_bus.ready <= 1'b0;
        forever begin
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 9) == 0) begin
                rsp_bus.ready <= 1'b1;
                repeat ($urandom_range(40, 120)) @(posedge i_clk);
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int               span;
        int               base;
        logic [KEY_W-1:0] k;
        t_lookup_result   none;

        none         = '0;
        req_count    = 0;
        rsp_count    = 0;
        fail_count   = 0;
        burst_left   = 0;
        stall_cycles = 0;
        exp_wr       = 0;
        exp_rd       = 0;
        dir_count    = 0;
        steady_send  = 1'b0;
        hold_rsp     = 1'b0;
        stamp_now    = '0;
        fill_level   = 0;
        cap_shadow   = CAP_RESET;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ent_live[i]  = 1'b0;
            ent_key[i]   = '0;
            ent_val[i]   = '0;
            ent_uses[i]  = '0;
            ent_stamp[i] = '0;
        end

        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_GET;
        req_bus.req_key   <= '0;
        req_bus.req_value <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.capacity  <= CAP_RESET;
        row_fixed         <= 1'b0;
        row_result        <= '0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // reset capacity first, then lowered below occupancy, zero, above max, one
        add_req(REQ_GET, 32'h0000_0000, 32'h1111_1111, 1'b1, none);
        add_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, none);
        add_req(REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
                mk_result(1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0));
        add_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, none);
        add_req(REQ_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1,
                mk_result(1'b1, 32'h0, 1'b0, 32'h0));
        add_req(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                mk_result(1'b1, 32'h8000_0000, 1'b0, 32'h0));
        add_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, none);
        add_req(REQ_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, none);
        add_cfg(5'd2);
        add_req(REQ_PUT, 32'h0000_0005, 32'h5555_5555, 1'b1,
                mk_result(1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF));
        add_req(REQ_PUT, 32'h0000_0006, 32'hAAAA_AAAA, 1'b0, none);
        add_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, none);
        add_cfg(5'd0);
        add_req(REQ_PUT, 32'h0000_0009, 32'h0000_0001, 1'b1, none);
        add_req(REQ_PUT, 32'h8000_0000, 32'hDEAD_BEEF, 1'b0, none);
        add_req(REQ_GET, 32'h0000_0009, 32'h0000_0000, 1'b1, none);
        add_cfg(5'd31);
        add_req(REQ_PUT, 32'h0000_0001, 32'h0000_0002, 1'b0, none);
        add_cfg(5'd1);
        add_req(REQ_PUT, 32'h0000_0040, 32'h0000_0000, 1'b0, none);
        add_req(REQ_PUT, 32'h0000_0041, 32'hFFFF_FFFE, 1'b0, none);
        add_req(REQ_GET, 32'h0000_0041, 32'h0000_0000, 1'b0, none);
        add_req(REQ_GET, 32'h0000_0040, 32'h0000_0000, 1'b0, none);
        add_cfg(5'd16);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < dir_count; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_capacity(dir_rows[r].key[CAP_W-1:0]);
            else
                send_req(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value,
                         dir_rows[r].fixed, dir_rows[r].result);
        end

        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            span = ((phase_caps[p] > MAX_ENTRIES) ? MAX_ENTRIES : int'(phase_caps[p])) + 5;
            base = $urandom_range(0, POOL_SIZE - 1);
            if (p == 2) begin
                // back-pressure: hold responses while requests keep coming
                steady_send = 1'b1;
                hold_rsp    = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == 40)
                    steady_send = 1'b0;
                if (p == 3 && n == 50)
                    wait_idle();
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[(base + $urandom_range(0, span - 1)) % POOL_SIZE];
                else
                    k = $urandom;
                send_req(1'($urandom_range(0, 1)), k, $urandom, 1'b0, none);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exp_wr != exp_rd) begin
            $error("%0d responses never arrived", exp_wr - exp_rd);
            fail_count++;
        end
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
